// File: design/pau_pkg.sv
// Shared types and constants of the polynomial arithmetic unit.
// No dependencies; every other file of the unit imports this package.
package pau_pkg;

	localparam int MAX_DEGREE = 31;
	localparam int FRAC_BITS  = 16;
	localparam int RES_CAP    = 62;

	localparam int DEPTH  = MAX_DEGREE + 1;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int DEG_W  = 5;
	localparam int MD_W   = 6;
	localparam int IDX_W  = 6;
	localparam int COEF_W = 32;
	localparam int PROD_W = 2 * COEF_W;
	localparam int ACC_W  = PROD_W + ADDR_W + 1;
	localparam int SH_W   = ACC_W - FRAC_BITS;

	typedef enum logic [1:0] {
		REQ_LOAD_A = 2'd0,
		REQ_LOAD_B = 2'd1,
		REQ_RUN    = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		OP_MUL   = 2'd0,
		OP_ADD   = 2'd1,
		OP_SUB   = 2'd2,
		OP_SCALE = 2'd3
	} op_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	typedef struct packed {
		logic              en;
		logic              sel_b;
		logic [ADDR_W-1:0] addr;
		logic [COEF_W-1:0] data;
	} coef_wr_t;

	typedef struct packed {
		op_t                      op;
		logic [DEG_W-1:0]         d1;
		logic [DEG_W-1:0]         d2;
		logic [MD_W-1:0]          md;
		logic signed [COEF_W-1:0] scale;
	} run_cmd_t;

	typedef struct packed {
		logic                     valid;
		op_t                      op;
		logic                     first;
		logic                     last;
		logic [IDX_W-1:0]         k;
		logic                     end_run;
		logic                     a_ok;
		logic                     b_ok;
		logic signed [COEF_W-1:0] scale;
	} term_ctl_t;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [COEF_W-1:0] value;
		logic              sat;
		logic              last;
	} res_beat_t;

endpackage

// File: design/pau_cmd_if.sv
// Command channel of the polynomial arithmetic unit: loads and run requests.
// Depends on pau_pkg for field widths.
interface pau_cmd_if;
	import pau_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               req_type;
	logic [DEG_W-1:0]         coef_index;
	logic signed [COEF_W-1:0] coef_value;
	logic [1:0]               operation;
	logic [DEG_W-1:0]         first_degree;
	logic [DEG_W-1:0]         second_degree;
	logic [MD_W-1:0]          max_degree;
	logic signed [COEF_W-1:0] scale_factor;

	modport source (
		output valid, req_type, coef_index, coef_value, operation,
		       first_degree, second_degree, max_degree, scale_factor,
		input  ready
	);
	modport sink (
		input  valid, req_type, coef_index, coef_value, operation,
		       first_degree, second_degree, max_degree, scale_factor,
		output ready
	);
endinterface

// File: design/pau_res_if.sv
// Result channel of the polynomial arithmetic unit: one coefficient per beat.
// Depends on pau_pkg for field widths.
interface pau_res_if;
	import pau_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [IDX_W-1:0]         out_index;
	logic signed [COEF_W-1:0] out_value;
	logic                     saturated;
	logic                     last;

	modport source (
		output valid, out_index, out_value, saturated, last,
		input  ready
	);
	modport sink (
		input  valid, out_index, out_value, saturated, last,
		output ready
	);
endinterface

// File: design/pau_coef_mem.sv
// Two coefficient memories (first and second polynomial), one write port
// shared by both and a registered read port on each. Depends on pau_pkg.
module pau_coef_mem (
	input  logic                      clk,
	input  pau_pkg::coef_wr_t         wr,
	input  logic                      rd_en,
	input  logic [pau_pkg::ADDR_W-1:0] rd_addr_a,
	input  logic [pau_pkg::ADDR_W-1:0] rd_addr_b,
	output logic [pau_pkg::COEF_W-1:0] rd_data_a,
	output logic [pau_pkg::COEF_W-1:0] rd_data_b
);
	import pau_pkg::*;

	logic [COEF_W-1:0] mem_a [DEPTH];
	logic [COEF_W-1:0] mem_b [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en && !wr.sel_b) begin
			mem_a[wr.addr] <= wr.data;
		end
		if (wr.en && wr.sel_b) begin
			mem_b[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem_a[rd_addr_a];
			rd_data_b <= mem_b[rd_addr_b];
		end
	end
endmodule

// File: design/pau_seq.sv
// Run sequencer: walks result indexes and, for products, the inner terms,
// issuing one memory read pair per cycle unless the pipeline stalls. Depends on pau_pkg.
module pau_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  pau_pkg::run_cmd_t          run_cmd,
	input  logic                       adv,
	output logic                       busy,
	output pau_pkg::term_ctl_t         issue,
	output logic                       rd_en,
	output logic [pau_pkg::ADDR_W-1:0] addr_a,
	output logic [pau_pkg::ADDR_W-1:0] addr_b
);
	import pau_pkg::*;

	seq_state_t state_q, state_nx;

	op_t                      op_q;
	logic [DEG_W-1:0]         d1_q, d2_q;
	logic [IDX_W-1:0]         rd_q, k_q;
	logic [DEG_W-1:0]         i_q;
	logic                     first_q;
	logic signed [COEF_W-1:0] sc_q;

	logic [DEG_W-1:0] d1_c, d2_c;
	logic [IDX_W-1:0] deg_sum, rd_new, rd_pick;
	logic [DEG_W-1:0] i_end, i_start_nx;
	logic [IDX_W-1:0] k_nx;
	logic             term_last, run_end;

	// Run setup: clip degrees and derive the result degree.
	always_comb begin
		d1_c    = (run_cmd.d1 > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : run_cmd.d1;
		d2_c    = (run_cmd.d2 > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : run_cmd.d2;
		deg_sum = IDX_W'(d1_c) + IDX_W'(d2_c);
		case (run_cmd.op)
			OP_MUL:   rd_pick = (IDX_W'(run_cmd.md) < deg_sum) ? IDX_W'(run_cmd.md) : deg_sum;
			OP_SCALE: rd_pick = IDX_W'(d1_c);
			default:  rd_pick = (d1_c > d2_c) ? IDX_W'(d1_c) : IDX_W'(d2_c);
		endcase
		rd_new = (rd_pick > IDX_W'(RES_CAP)) ? IDX_W'(RES_CAP) : rd_pick;
	end

	// Inner term range of a product coefficient k: i from max(0, k-d2) to min(d1, k).
	always_comb begin
		i_end      = (k_q > IDX_W'(d1_q)) ? d1_q : DEG_W'(k_q);
		k_nx       = k_q + IDX_W'(1);
		i_start_nx = (k_nx > IDX_W'(d2_q)) ? DEG_W'(k_nx - IDX_W'(d2_q)) : '0;
		term_last  = (op_q != OP_MUL) || (i_q == i_end);
		run_end    = (k_q == rd_q);
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			SEQ_IDLE: begin
				if (start) begin
					state_nx = SEQ_RUN;
				end
			end
			SEQ_RUN: begin
				if (adv && term_last && run_end) begin
					state_nx = SEQ_IDLE;
				end
			end
			default: state_nx = SEQ_IDLE;
		endcase
	end

	always_comb begin
		busy          = (state_q == SEQ_RUN);
		rd_en         = busy && adv;
		issue.valid   = busy;
		issue.op      = op_q;
		issue.first   = first_q;
		issue.last    = term_last;
		issue.k       = k_q;
		issue.end_run = run_end;
		issue.a_ok    = (k_q <= IDX_W'(d1_q));
		issue.b_ok    = (k_q <= IDX_W'(d2_q));
		issue.scale   = sc_q;
		if (op_q == OP_MUL) begin
			addr_a = ADDR_W'(i_q);
			addr_b = ADDR_W'(k_q - IDX_W'(i_q));
		end else begin
			addr_a = ADDR_W'(k_q);
			addr_b = ADDR_W'(k_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == SEQ_IDLE) begin
			op_q    <= run_cmd.op;
			d1_q    <= d1_c;
			d2_q    <= d2_c;
			rd_q    <= rd_new;
			sc_q    <= run_cmd.scale;
			k_q     <= '0;
			i_q     <= '0;
			first_q <= 1'b1;
		end else if (state_q == SEQ_RUN && adv) begin
			if (term_last) begin
				k_q     <= k_nx;
				i_q     <= i_start_nx;
				first_q <= 1'b1;
			end else begin
				i_q     <= i_q + DEG_W'(1);
				first_q <= 1'b0;
			end
		end
	end
endmodule

// File: design/pau_datapath.sv
// Arithmetic pipeline: multiply, add or subtract, wide accumulate, round and saturate,
// and the output register. Depends on pau_pkg.
module pau_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pau_pkg::term_ctl_t         issue,
	input  logic [pau_pkg::COEF_W-1:0] rd_data_a,
	input  logic [pau_pkg::COEF_W-1:0] rd_data_b,
	input  logic                       out_ready,
	output logic                       adv,
	output logic                       pipe_busy,
	output logic                       out_valid,
	output pau_pkg::res_beat_t         out_beat
);
	import pau_pkg::*;

	localparam logic [ACC_W-1:0] RND_HALF =
		(FRAC_BITS > 0) ? (ACC_W'(1) << (FRAC_BITS - 1)) : '0;

	logic                     v_s1;
	term_ctl_t                ctl_s1;

	logic                     v_s2, first_s2, last_s2, end_s2;
	logic [IDX_W-1:0]         k_s2;
	logic signed [PROD_W-1:0] term_s2;

	logic                     v_s3, end_s3;
	logic [IDX_W-1:0]         k_s3;
	logic signed [ACC_W-1:0]  acc_s3;

	logic                     out_valid_q;
	res_beat_t                beat_q;

	logic signed [COEF_W-1:0] mul_a, mul_b, add_a, add_b;
	logic signed [PROD_W-1:0] prod, term_nx;
	logic signed [COEF_W:0]   sumdiff;
	logic signed [ACC_W-1:0]  term_ext, rnd;
	logic signed [SH_W-1:0]   shifted;
	logic                     fits;
	res_beat_t                beat_nx;

	// The whole pipeline moves together; it halts only while a finished
	// beat sits unaccepted in the output register.
	assign adv       = !out_valid_q || out_ready;
	assign pipe_busy = v_s1 || v_s2 || v_s3;
	assign out_valid = out_valid_q;
	assign out_beat  = beat_q;

	always_comb begin
		mul_a   = $signed(rd_data_a);
		mul_b   = (ctl_s1.op == OP_SCALE) ? ctl_s1.scale : $signed(rd_data_b);
		prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
		add_a   = ctl_s1.a_ok ? $signed(rd_data_a) : '0;
		add_b   = ctl_s1.b_ok ? $signed(rd_data_b) : '0;
		if (ctl_s1.op == OP_SUB) begin
			sumdiff = (COEF_W+1)'(add_a) - (COEF_W+1)'(add_b);
		end else begin
			sumdiff = (COEF_W+1)'(add_a) + (COEF_W+1)'(add_b);
		end
		// Sums are placed at the scale of a product so that rounding leaves them exact.
		if (ctl_s1.op == OP_MUL || ctl_s1.op == OP_SCALE) begin
			term_nx = prod;
		end else begin
			term_nx = PROD_W'(sumdiff) <<< FRAC_BITS;
		end
	end

	always_comb begin
		term_ext = ACC_W'(term_s2);
		rnd      = acc_s3 + $signed(RND_HALF);
		shifted  = SH_W'(rnd >>> FRAC_BITS);
		fits     = (&shifted[SH_W-1:COEF_W-1]) || !(|shifted[SH_W-1:COEF_W-1]);
		beat_nx.idx  = k_s3;
		beat_nx.last = end_s3;
		beat_nx.sat  = !fits;
		if (fits) begin
			beat_nx.value = shifted[COEF_W-1:0];
		end else if (shifted[SH_W-1]) begin
			beat_nx.value = {1'b1, {(COEF_W-1){1'b0}}};
		end else begin
			beat_nx.value = {1'b0, {(COEF_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2 && last_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= issue;

			first_s2 <= ctl_s1.first;
			last_s2  <= ctl_s1.last;
			end_s2   <= ctl_s1.end_run;
			k_s2     <= ctl_s1.k;
			term_s2  <= term_nx;

			if (v_s2) begin
				acc_s3 <= first_s2 ? term_ext : acc_s3 + term_ext;
			end
			k_s3   <= k_s2;
			end_s3 <= end_s2;

			if (v_s3) begin
				beat_q <= beat_nx;
			end
		end
	end
endmodule

// File: design/polynomial_arithmetic_unit.sv
// Top level of the polynomial arithmetic unit: command decode, coefficient
// memories, run sequencer and arithmetic pipeline. Depends on pau_pkg,
// pau_cmd_if, pau_res_if, pau_coef_mem, pau_seq and pau_datapath.
//
//   Port   Dir   Beat contents
//   cmd    sink  load of one coefficient (first or second) or a run request
//   res    src   one result coefficient: index, value, saturation flag, last
//
// A load is accepted back to back while the unit is idle.
// A run issues one memory read pair and one multiply-accumulate per cycle
// while the res channel does not stall: a product walks the inner terms of
// every result index, while sum, difference and scale take one term per
// result coefficient, through the read, term, accumulate and output registers.
// cmd.ready is low from the run request until its last term leaves the
// accumulator, so loads never overlap a run's reads. A stalled res channel
// freezes the whole pipeline in place; nothing is dropped or repeated.
// Reset clears only control state; the coefficient memories are not cleared,
// so only entries loaded since reset should be covered by a run's degrees.
module polynomial_arithmetic_unit (
	input logic       clk,
	input logic       arst_n,
	pau_cmd_if.sink   cmd,
	pau_res_if.source res
);
	import pau_pkg::*;

	logic              seq_busy, pipe_busy, adv, accept, start, rd_en;
	coef_wr_t          wr;
	run_cmd_t          run_cmd;
	term_ctl_t         issue;
	logic [ADDR_W-1:0] addr_a, addr_b;
	logic [COEF_W-1:0] rd_data_a, rd_data_b;
	logic              out_valid;
	res_beat_t         out_beat;

	// The unit takes a beat only when no run is in flight.
	assign cmd.ready = !seq_busy && !pipe_busy;
	assign accept    = cmd.valid && cmd.ready;
	assign start     = accept && (req_t'(cmd.req_type) == REQ_RUN);

	// Loads beyond the store depth are dropped; request code 3 does nothing.
	always_comb begin
		wr.en    = accept
		           && (req_t'(cmd.req_type) == REQ_LOAD_A || req_t'(cmd.req_type) == REQ_LOAD_B)
		           && (cmd.coef_index <= DEG_W'(MAX_DEGREE));
		wr.sel_b = (req_t'(cmd.req_type) == REQ_LOAD_B);
		wr.addr  = ADDR_W'(cmd.coef_index);
		wr.data  = cmd.coef_value;
	end

	always_comb begin
		run_cmd.op    = op_t'(cmd.operation);
		run_cmd.d1    = cmd.first_degree;
		run_cmd.d2    = cmd.second_degree;
		run_cmd.md    = cmd.max_degree;
		run_cmd.scale = cmd.scale_factor;
	end

	pau_coef_mem u_mem (
		.clk       (clk),
		.wr        (wr),
		.rd_en     (rd_en),
		.rd_addr_a (addr_a),
		.rd_addr_b (addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	pau_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.run_cmd (run_cmd),
		.adv     (adv),
		.busy    (seq_busy),
		.issue   (issue),
		.rd_en   (rd_en),
		.addr_a  (addr_a),
		.addr_b  (addr_b)
	);

	pau_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b),
		.out_ready (res.ready),
		.adv       (adv),
		.pipe_busy (pipe_busy),
		.out_valid (out_valid),
		.out_beat  (out_beat)
	);

	// The output register inside the datapath drives the result beat directly.
	assign res.valid     = out_valid;
	assign res.out_index = out_beat.idx;
	assign res.out_value = out_beat.value;
	assign res.saturated = out_beat.sat;
	assign res.last      = out_beat.last;
endmodule
